[rtl/triangle_normal_tangent_macros.svh]
// Assertion helpers for the top-level RTL file. Each use states one property
// that is checked on every rising clock edge outside of reset.
`ifndef TRIANGLE_NORMAL_TANGENT_MACROS_SVH
`define TRIANGLE_NORMAL_TANGENT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define TNT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define TNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tnt_pkg.sv]
package tnt_pkg;

  localparam int COORD_W        = 24;
  localparam int NUM_COORDS     = 9;
  localparam int EDGE_W         = COORD_W + 1;
  localparam int PROD_W         = 2 * EDGE_W;
  localparam int CROSS_W        = PROD_W + 1;

  localparam int UNIT_FRAC_BITS = 14;
  localparam int UNIT_W         = UNIT_FRAC_BITS + 2;
  localparam int QUO_W          = UNIT_FRAC_BITS + 2;
  localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << UNIT_FRAC_BITS;

  // Normalizer internals: magnitudes are scaled to NRM_W bits, the largest with its top bit set.
  localparam int NRM_W          = 30;
  localparam int SUM_W          = 2 * NRM_W + 2;
  localparam int LEN_W          = NRM_W + 1;
  localparam int SQRT_STEPS     = LEN_W;
  localparam int DIV_W          = NRM_W + UNIT_FRAC_BITS + 2;
  localparam int NORM_LAT       = 4 + 1 + SQRT_STEPS + 1 + QUO_W + 1;

  // Projection of the first edge onto the normal.
  localparam int DOT_W          = EDGE_W + UNIT_W + 2;
  localparam int DQ_W           = DOT_W - UNIT_FRAC_BITS + 2;
  localparam int TV_W           = EDGE_W + UNIT_FRAC_BITS + 1 > UNIT_W + DQ_W + 1 ?
                                  EDGE_W + UNIT_FRAC_BITS + 1 : UNIT_W + DQ_W + 1;

  localparam int OUT_W          = 16;
  localparam int IN_DATA_W      = NUM_COORDS * COORD_W;
  localparam int OUT_DATA_W     = 6 * OUT_W;
  localparam int OUT_USER_W     = 2;

endpackage

[rtl/tnt_norm.sv]
module tnt_norm
  import tnt_pkg::*;
#(
  parameter int W  = CROSS_W,
  parameter int SW = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [W-1:0]      vec_i [3],
  input  logic [SW-1:0]            side_i,
  output logic                     valid_o,
  output logic                     nz_o,
  output logic signed [UNIT_W-1:0] unit_o [3],
  output logic [SW-1:0]            side_o
);

  localparam int PW = $clog2(W + 1);
  // Carried control word: {side, signs[2:0], nonzero}.
  localparam int CW = SW + 4;

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic [W-1:0]         m1_q [3];
  logic [W-1:0]         m2_q [3];
  logic [PW-1:0]        pos2_q;
  logic [NRM_W-1:0]     n3_q [3];
  logic [NRM_W-1:0]     n4_q [3];
  logic [2*NRM_W-1:0]   sq4_q [3];
  logic [CW-1:0]        c1_q, c2_q, c3_q, c4_q;
  logic [W-1:0]         mx_d;
  logic [PW-1:0]        pos_d;
  logic [W+NRM_W-1:0]   sh_d [3];

  logic                 qv_q [SQRT_STEPS+1];
  logic [SUM_W-1:0]     qx_q [SQRT_STEPS+1];
  logic [SUM_W-1:0]     qr_q [SQRT_STEPS+1];
  logic [NRM_W-1:0]     qn_q [SQRT_STEPS+1][3];
  logic [CW-1:0]        qc_q [SQRT_STEPS+1];
  logic [LEN_W-1:0]     len_d;

  logic                 dv_q [QUO_W+1];
  logic [DIV_W-1:0]     dr_q [QUO_W+1][3];
  logic [QUO_W-1:0]     dq_q [QUO_W+1][3];
  logic [LEN_W-1:0]     dd_q [QUO_W+1];
  logic [CW-1:0]        dc_q [QUO_W+1];

  logic                 fv_q, fnz_q;
  logic signed [UNIT_W-1:0] fu_q [3];
  logic signed [UNIT_W-1:0] unit_d [3];
  logic [SW-1:0]        fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      qv_q[0] <= 1'b0;
      dv_q[0] <= 1'b0;
      fv_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      qv_q[0] <= v4_q;
      dv_q[0] <= qv_q[SQRT_STEPS];
      fv_q <= dv_q[QUO_W];
    end
  end

  // Largest magnitude and the position of its leading one.
  always_comb begin
    mx_d = m1_q[0];
    if (m1_q[1] > mx_d) mx_d = m1_q[1];
    if (m1_q[2] > mx_d) mx_d = m1_q[2];
    pos_d = '0;
    for (int b = 0; b < W; b++) begin
      if (mx_d[b]) pos_d = PW'(b);
    end
  end

  // Scale so that the leading one of the largest magnitude lands on bit NRM_W-1.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_d[i] = {m2_q[i], {NRM_W{1'b0}}} >> (pos2_q + PW'(1));
    end
  end

  assign len_d = qr_q[SQRT_STEPS][LEN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m1_q[i]  <= vec_i[i][W-1] ? W'(-vec_i[i]) : W'(vec_i[i]);
        m2_q[i]  <= m1_q[i];
        n3_q[i]  <= sh_d[i][NRM_W-1:0];
        n4_q[i]  <= n3_q[i];
        sq4_q[i] <= n3_q[i] * n3_q[i];
        dr_q[0][i] <= DIV_W'({qn_q[SQRT_STEPS][i], {UNIT_FRAC_BITS{1'b0}}})
                      + DIV_W'(len_d >> 1);
        dq_q[0][i] <= '0;
      end
      c1_q    <= {side_i, vec_i[2][W-1], vec_i[1][W-1], vec_i[0][W-1], 1'b0};
      c2_q    <= {c1_q[CW-1:1], |mx_d};
      c3_q    <= c2_q;
      c4_q    <= c3_q;
      pos2_q  <= pos_d;
      qx_q[0] <= SUM_W'(sq4_q[0]) + SUM_W'(sq4_q[1]) + SUM_W'(sq4_q[2]);
      qr_q[0] <= '0;
      qn_q[0] <= n4_q;
      qc_q[0] <= c4_q;
      dd_q[0] <= len_d;
      dc_q[0] <= qc_q[SQRT_STEPS];
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (2 * (SQRT_STEPS - k));
    logic [SUM_W-1:0] trial;

    assign trial = qr_q[k-1] + STEP_BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qv_q[k] <= 1'b0;
      end else if (en_i) begin
        qv_q[k] <= qv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (qx_q[k-1] >= trial) begin
          qx_q[k] <= qx_q[k-1] - trial;
          qr_q[k] <= (qr_q[k-1] >> 1) + STEP_BIT;
        end else begin
          qx_q[k] <= qx_q[k-1];
          qr_q[k] <= qr_q[k-1] >> 1;
        end
        qn_q[k] <= qn_q[k-1];
        qc_q[k] <= qc_q[k-1];
      end
    end
  end

  // Restoring division of each scaled magnitude by the length, one quotient bit per stage.
  for (genvar t = 1; t <= QUO_W; t++) begin : g_div
    localparam int J = QUO_W - t;
    logic [DIV_W-1:0] dsub;

    assign dsub = DIV_W'(dd_q[t-1]) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[t] <= 1'b0;
      end else if (en_i) begin
        dv_q[t] <= dv_q[t-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (dr_q[t-1][i] >= dsub) begin
            dr_q[t][i] <= dr_q[t-1][i] - dsub;
            dq_q[t][i] <= dq_q[t-1][i] | (QUO_W'(1) << J);
          end else begin
            dr_q[t][i] <= dr_q[t-1][i];
            dq_q[t][i] <= dq_q[t-1][i];
          end
        end
        dd_q[t] <= dd_q[t-1];
        dc_q[t] <= dc_q[t-1];
      end
    end
  end

  // Clamp to one, restore the sign; a zero vector gives zeros.
  always_comb begin
    logic [QUO_W-1:0] q;
    q = '0;
    for (int i = 0; i < 3; i++) begin
      q = dq_q[QUO_W][i];
      if (q > QUO_W'(UNIT_ONE)) q = QUO_W'(UNIT_ONE);
      if (!dc_q[QUO_W][0]) begin
        unit_d[i] = '0;
      end else if (dc_q[QUO_W][i+1]) begin
        unit_d[i] = -$signed(UNIT_W'(q));
      end else begin
        unit_d[i] = $signed(UNIT_W'(q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fnz_q <= dc_q[QUO_W][0];
      fu_q  <= unit_d;
      fs_q  <= dc_q[QUO_W][CW-1:4];
    end
  end

  assign valid_o = fv_q;
  assign nz_o    = fnz_q;
  assign unit_o  = fu_q;
  assign side_o  = fs_q;

endmodule

[rtl/triangle_normal_tangent.sv]
// Pipeline: 118 register stages from an input transfer until its result sits in the output
// register, the first loading at the transfer edge; they are set by two normalizers
// in series (54 stages each: square root and divide bit by bit).
// Throughput: one triangle per cycle; the pipeline stalls as a whole only when the
// output register and its skid register are both full.
// Reset: asynchronous, active low; clears all valid bits, payload registers keep data.
`include "triangle_normal_tangent_macros.svh"

module triangle_normal_tangent
  import tnt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 24 bits each from bit 0 up.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z, 16 bits each.
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // normal_degenerate (bit 0), tangent_fallback (bit 1).
  output logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  localparam int PD_W  = EDGE_W + UNIT_W;
  localparam int ES_W  = EDGE_W + UNIT_FRAC_BITS;
  localparam int ND_W  = UNIT_W + DQ_W;
  localparam int AXC_W = UNIT_W + 4;
  localparam logic [AXC_W-1:0] AXIS_LIMIT = AXC_W'(9) * AXC_W'(UNIT_ONE);
  localparam logic [DOT_W:0]   DOT_HALF   = (DOT_W + 1)'(1) << (UNIT_FRAC_BITS - 1);

  // The whole pipeline moves together; it holds only while the skid register is full,
  // so the input side is decoupled from the output handshake by one register.
  logic en;
  logic v_q [9];

  logic signed [COORD_W-1:0] crd [NUM_COORDS];
  logic signed [EDGE_W-1:0]  e1_1_q [3], e2_1_q [3];
  logic signed [EDGE_W-1:0]  e1_2_q [3], e1_3_q [3];
  logic signed [PROD_W-1:0]  p2_q [6];
  logic signed [CROSS_W-1:0] cr3_q [3];

  // Face normal from the first normalizer; the first edge rides along as side data.
  logic                      va, nza;
  logic signed [UNIT_W-1:0]  una [3];
  logic [3*EDGE_W-1:0]       sidea;
  logic signed [EDGE_W-1:0]  e1a [3];
  logic signed [UNIT_W-1:0]  n_d [3];

  logic signed [UNIT_W-1:0]  n4_q [3], n5_q [3], n6_q [3], n7_q [3], n8_q [3], n9_q [3];
  logic signed [EDGE_W-1:0]  e14_q [3], e15_q [3], e16_q [3], e17_q [3];
  logic                      dg4_q, dg5_q, dg6_q, dg7_q, dg8_q, dg9_q;
  logic signed [PD_W-1:0]    pd4_q [3];
  logic signed [DOT_W-1:0]   dot5_q;
  logic [UNIT_W-1:0]         nyabs;
  logic signed [UNIT_W-1:0]  ax_d [3];
  logic signed [UNIT_W-1:0]  ax5_q [3], ax6_q [3], ax7_q [3], ax8_q [3], ax9_q [3];
  logic [DOT_W-1:0]          dmag6_q;
  logic                      dneg6_q;
  logic [DQ_W-1:0]           rq_d;
  logic signed [DQ_W-1:0]    dq7_q;
  logic signed [ND_W-1:0]    nd8_q [3];
  logic signed [ES_W-1:0]    es8_q [3];
  logic signed [TV_W-1:0]    tv9_q [3];
  logic [3*UNIT_W-1:0]       n9_pk;

  // Tangent from the projected edge, and the axis cross used as its fallback.
  logic                      vb, nzb, vc, nzc, dgc;
  logic signed [UNIT_W-1:0]  unb [3], unc [3];
  logic [3*UNIT_W-1:0]       sideb;

  logic                      res_v;
  logic [OUT_DATA_W-1:0]     res_data;
  logic [OUT_USER_W-1:0]     res_user;
  logic signed [UNIT_W-1:0]  tan_d [3];
  logic signed [UNIT_W-1:0]  nrm_d [3];

  logic                      out_v_q, sk_v_q;
  logic [OUT_DATA_W-1:0]     out_data_q, sk_data_q;
  logic [OUT_USER_W-1:0]     out_user_q, sk_user_q;
  logic                      load_out, load_sk, out_from_sk;

  assign en = !sk_v_q;
  assign s_axis_tready_o = en;

  for (genvar f = 0; f < NUM_COORDS; f++) begin : g_crd
    assign crd[f] = s_axis_tdata_i[f*COORD_W +: COORD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 9; s++) v_q[s] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid_i;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= va;
      for (int s = 4; s < 9; s++) v_q[s] <= v_q[s-1];
    end
  end

  // Edges, the six partial products and the cross product.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_1_q[i] <= EDGE_W'(crd[3+i]) - EDGE_W'(crd[i]);
        e2_1_q[i] <= EDGE_W'(crd[6+i]) - EDGE_W'(crd[i]);
      end
      p2_q[0] <= e1_1_q[1] * e2_1_q[2];
      p2_q[1] <= e1_1_q[2] * e2_1_q[1];
      p2_q[2] <= e1_1_q[2] * e2_1_q[0];
      p2_q[3] <= e1_1_q[0] * e2_1_q[2];
      p2_q[4] <= e1_1_q[0] * e2_1_q[1];
      p2_q[5] <= e1_1_q[1] * e2_1_q[0];
      e1_2_q  <= e1_1_q;
      for (int i = 0; i < 3; i++) begin
        cr3_q[i] <= CROSS_W'(p2_q[2*i]) - CROSS_W'(p2_q[2*i+1]);
      end
      e1_3_q <= e1_2_q;
    end
  end

  tnt_norm #(
    .W  (CROSS_W),
    .SW (3 * EDGE_W)
  ) u_norm_face (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[2]),
    .vec_i   (cr3_q),
    .side_i  ({e1_3_q[2], e1_3_q[1], e1_3_q[0]}),
    .valid_o (va),
    .nz_o    (nza),
    .unit_o  (una),
    .side_o  (sidea)
  );

  // A zero-area triangle gets the +Y normal. The edge dotted with the normal is
  // formed exactly, then rounded half away from zero back to the coordinate scale.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1a[i] = $signed(sidea[i*EDGE_W +: EDGE_W]);
      n_d[i] = nza ? una[i] : '0;
    end
    if (!nza) n_d[1] = $signed(UNIT_ONE);
  end

  // The fallback axis is +Y unless the normal is within about 26 degrees of the Y axis either way.
  always_comb begin
    nyabs = n4_q[1][UNIT_W-1] ? UNIT_W'(-n4_q[1]) : UNIT_W'(n4_q[1]);
    if (AXC_W'(nyabs) * AXC_W'(10) < AXIS_LIMIT) begin
      ax_d[0] = n4_q[2];
      ax_d[1] = '0;
      ax_d[2] = -n4_q[0];
    end else begin
      ax_d[0] = '0;
      ax_d[1] = -n4_q[2];
      ax_d[2] = n4_q[1];
    end
  end

  assign rq_d = DQ_W'(((DOT_W + 1)'(dmag6_q) + DOT_HALF) >> UNIT_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n4_q[i]  <= n_d[i];
        pd4_q[i] <= e1a[i] * n_d[i];
        e14_q[i] <= e1a[i];
        nd8_q[i] <= n7_q[i] * dq7_q;
        es8_q[i] <= ES_W'(e17_q[i]) <<< UNIT_FRAC_BITS;
        tv9_q[i] <= TV_W'(es8_q[i]) - TV_W'(nd8_q[i]);
      end
      dg4_q   <= !nza;
      dot5_q  <= DOT_W'(pd4_q[0]) + DOT_W'(pd4_q[1]) + DOT_W'(pd4_q[2]);
      ax5_q   <= ax_d;
      dneg6_q <= dot5_q[DOT_W-1];
      dmag6_q <= dot5_q[DOT_W-1] ? DOT_W'(-dot5_q) : DOT_W'(dot5_q);
      dq7_q   <= dneg6_q ? -$signed(rq_d) : $signed(rq_d);
      n5_q  <= n4_q;  n6_q  <= n5_q;  n7_q  <= n6_q;  n8_q <= n7_q;  n9_q <= n8_q;
      e15_q <= e14_q; e16_q <= e15_q; e17_q <= e16_q;
      dg5_q <= dg4_q; dg6_q <= dg5_q; dg7_q <= dg6_q; dg8_q <= dg7_q; dg9_q <= dg8_q;
      ax6_q <= ax5_q; ax7_q <= ax6_q; ax8_q <= ax7_q; ax9_q <= ax8_q;
    end
  end

  assign n9_pk = {n9_q[2], n9_q[1], n9_q[0]};

  tnt_norm #(
    .W  (TV_W),
    .SW (3 * UNIT_W)
  ) u_norm_tan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[8]),
    .vec_i   (tv9_q),
    .side_i  (n9_pk),
    .valid_o (vb),
    .nz_o    (nzb),
    .unit_o  (unb),
    .side_o  (sideb)
  );

  tnt_norm #(
    .W  (UNIT_W),
    .SW (1)
  ) u_norm_axis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[8]),
    .vec_i   (ax9_q),
    .side_i  (dg9_q),
    .valid_o (vc),
    .nz_o    (nzc),
    .unit_o  (unc),
    .side_o  (dgc)
  );

  // Tangent choice: projected edge, else axis cross, else +X.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_d[i] = $signed(sideb[i*UNIT_W +: UNIT_W]);
      if (nzb) begin
        tan_d[i] = unb[i];
      end else if (nzc) begin
        tan_d[i] = unc[i];
      end else begin
        tan_d[i] = '0;
      end
    end
    if (!nzb && !nzc) tan_d[0] = $signed(UNIT_ONE);
    res_v    = vb && vc;
    res_data = {OUT_W'(tan_d[2]), OUT_W'(tan_d[1]), OUT_W'(tan_d[0]),
                OUT_W'(nrm_d[2]), OUT_W'(nrm_d[1]), OUT_W'(nrm_d[0])};
    res_user = {!nzb, dgc};
  end

  // Output register with a skid register behind it. A result that arrives while
  // the output is stalled parks in the skid register, which then stops the pipeline.
  always_comb begin
    out_from_sk = out_v_q && m_axis_tready_i && sk_v_q;
    load_out    = en && res_v && (!out_v_q || m_axis_tready_i);
    load_sk     = en && res_v && out_v_q && !m_axis_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      if (out_from_sk) begin
        sk_v_q <= 1'b0;
      end else if (load_sk) begin
        sk_v_q <= 1'b1;
      end
      if (out_from_sk || load_out) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_sk) begin
      out_data_q <= sk_data_q;
      out_user_q <= sk_user_q;
    end else if (load_out) begin
      out_data_q <= res_data;
      out_user_q <= res_user;
    end
    if (load_sk) begin
      sk_data_q <= res_data;
      sk_user_q <= res_user;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `TNT_ASSERT_IMPL(a_skid_behind_out, sk_v_q, out_v_q, "skid register full while output empty")
  `TNT_ASSERT_NEXT(a_skid_holds, sk_v_q && !m_axis_tready_i, sk_v_q && $stable(sk_data_q), "skid register lost its transfer")
  `TNT_ASSERT_NEXT(a_stall_parks, out_v_q && !m_axis_tready_i && en && res_v, sk_v_q, "result arriving at a stalled output was not parked")
  `TNT_ASSERT_IMPL(a_degenerate_up, out_v_q && out_user_q[0], out_data_q[OUT_W +: OUT_W] == OUT_W'(UNIT_ONE) && out_data_q[0 +: OUT_W] == '0, "degenerate normal is not +Y")

endmodule
